/* design/acctilt_pkg.sv */
// shared constants, register indexes and arctangent table for the tilt filter
package acctilt_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 6;
    localparam int CORDIC_STEPS_DEF    = 16;

    localparam int ACC_W   = 16;  // accelerometer axis width
    localparam int PITCH_W = 14;
    localparam int ROLL_W  = 15;
    localparam int SERVO_W = 14;
    localparam int GAIN_W  = 9;
    localparam int ELIM_W  = 8;
    localparam int CFG_W   = 14;
    localparam int CFG_AW  = 2;

    localparam int SQ_W    = 32;  // y*y + z*z
    localparam int ROOT_W  = 16;
    localparam int OPND_W  = 17;  // cordic operands, signed
    localparam int VEC_W   = 34;  // cordic x/y datapath
    localparam int FINE_W  = 27;  // angle in 1/65536 degree

    localparam logic [CFG_AW-1:0] REG_FILTER_GAIN  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_ERROR_LIMIT  = 2'd1;
    localparam logic [CFG_AW-1:0] REG_SERVO_OFFSET = 2'd2;
    localparam logic [CFG_AW-1:0] REG_SERVO_MAX    = 2'd3;

    // 180 degrees in 1/65536 degree
    localparam logic signed [FINE_W-1:0] DEG180_FINE = 27'sd11796480;

    // atan(2^-i) in 1/65536 degree
    function automatic logic [21:0] atan_fine(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

/* design/acctilt_sqrt.sv */
// digit-serial integer square root, two operand bits per cycle
module acctilt_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [acctilt_pkg::SQ_W-1:0] operand,
    output logic                         done,
    output logic [acctilt_pkg::ROOT_W-1:0] root
);
    import acctilt_pkg::*;

    logic [SQ_W-1:0]   op_reg, op_next;
    logic [ROOT_W+1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ROOT_W+1:0] rem_sh, trial;

    always_comb
    begin
        rem_sh    = {rem_reg[ROOT_W-1:0], op_reg[SQ_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        op_next   = op_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            op_next   = operand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            op_next = {op_reg[SQ_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

/* design/acctilt_cordic.sv */
// vectoring cordic, one micro-rotation per cycle, angle in 1/65536 degree
module acctilt_cordic #(
    parameter int CORDIC_STEPS = acctilt_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [acctilt_pkg::OPND_W-1:0] xa,
    input  logic signed [acctilt_pkg::OPND_W-1:0] ya,
    input  logic signed [acctilt_pkg::FINE_W-1:0] base,
    output logic                                 done,
    output logic signed [acctilt_pkg::FINE_W-1:0] angle
);
    import acctilt_pkg::*;

    localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    logic signed [VEC_W-1:0]  x_reg, x_next, y_reg, y_next, dx, dy;
    logic signed [FINE_W-1:0] a_reg, a_next, t;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic                     busy_reg, busy_next, done_reg, done_next;

    always_comb
    begin
        dx        = y_reg >>> cnt_reg;
        dy        = x_reg >>> cnt_reg;
        t         = FINE_W'($signed({1'b0, atan_fine(5'(cnt_reg))}));
        x_next    = x_reg;
        y_next    = y_reg;
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next   = VEC_W'(xa) <<< 14;
            y_next   = VEC_W'(ya) <<< 14;
            a_next   = base;
            cnt_next = '0;
            // zero vector gives the base angle
            if (xa == '0 && ya == '0)
                done_next = 1'b1;
            else
                busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!y_reg[VEC_W-1])
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                a_next = a_reg + t;
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                a_next = a_reg - t;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        a_reg <= a_next;
    end

    assign done  = done_reg;
    assign angle = a_reg;
endmodule

/* design/accel_tilt_filter_servo_map.sv */
// top level: sample check, sqrt and cordic sequencing, low-pass filters, servo map
// sequence: an invalid sample goes straight to the finish state; a valid sample runs two
// square states, the sqrt, two passes on one shared cordic, each followed by unit, multiply
// and accumulate states, then the finish state, which waits for a free output register
// flow: one transaction at a time; next input taken the cycle after the result is
// registered, so no new sample is taken before the last one is through
// reset: angle states and error count clear, registers return to their defaults
module accel_tilt_filter_servo_map #(
    parameter int ANGLE_FRAC_BITS = acctilt_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = acctilt_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [acctilt_pkg::CFG_AW-1:0]        cfg_addr,
    input  logic [acctilt_pkg::CFG_W-1:0]         cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [acctilt_pkg::ACC_W-1:0]   accel_x,
    input  logic signed [acctilt_pkg::ACC_W-1:0]   accel_y,
    input  logic signed [acctilt_pkg::ACC_W-1:0]   accel_z,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  updated,
    output logic                                  sensor_reset,
    output logic signed [acctilt_pkg::PITCH_W-1:0] pitch_out,
    output logic signed [acctilt_pkg::ROLL_W-1:0]  roll_out,
    output logic [acctilt_pkg::SERVO_W-1:0]        servo_angle
);
    import acctilt_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQY  = 4'd1;
    localparam logic [3:0] S_SQZ  = 4'd2;
    localparam logic [3:0] S_SQRT = 4'd3;
    localparam logic [3:0] S_CORD = 4'd4;
    localparam logic [3:0] S_UNIT = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_ACC  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    localparam int SHR = 16 - ANGLE_FRAC_BITS;

    // configuration registers
    logic [GAIN_W-1:0]  gain_reg;
    logic [ELIM_W-1:0]  elim_reg;
    logic [SERVO_W-1:0] offset_reg, smax_reg;

    // control
    logic [3:0]  state_reg, state_next;
    logic        roll_reg, roll_next;
    logic [7:0]  ecnt_reg, ecnt_next;
    logic        upd_reg, upd_next, rst_req_reg, rst_req_next;

    // angle state
    logic signed [PITCH_W-1:0] pitch_reg, pitch_next;
    logic signed [ROLL_W-1:0]  roll_st_reg, roll_st_next;

    // payload
    logic signed [ACC_W-1:0]  x_reg, y_reg, z_reg;
    logic [SQ_W-1:0]          sqy_reg;
    logic signed [ROLL_W-1:0] units_reg, units_next;
    logic signed [26:0]       prod_reg;

    // output register
    logic                      ov_reg;
    logic                      o_upd_reg, o_rst_reg;
    logic signed [PITCH_W-1:0] o_pitch_reg;
    logic signed [ROLL_W-1:0]  o_roll_reg;
    logic [SERVO_W-1:0]        o_servo_reg, servo_val;

    // sub-units
    logic                     sq_start, sq_done, cd_start, cd_done;
    logic [SQ_W-1:0]          sq_op;
    logic [ROOT_W-1:0]        sq_root;
    logic signed [OPND_W-1:0] cd_xa, cd_ya;
    logic signed [FINE_W-1:0] cd_base, cd_angle;

    // datapath temporaries
    logic              accept, invalid, out_free;
    logic [7:0]        ecnt_inc;
    logic signed [FINE_W-1:0]  fine_rnd;
    logic signed [ROLL_W-1:0]  lo_lim, hi_lim, s_cur;
    logic signed [16:0]        diff;
    logic signed [GAIN_W:0]    gain_sat;
    logic signed [19:0]        acc_sum;
    logic signed [15:0]        servo_sum;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !ov_reg || out_ready;
    assign invalid  = (accel_x == '0 && accel_y == '0 && accel_z == '0) ||
                      (accel_x == '1 && accel_y == '1 && accel_z == '1);
    assign ecnt_inc = (ecnt_reg == 8'hFF) ? ecnt_reg : ecnt_reg + 8'd1;

    // y*y is registered first; the sqrt takes y*y + z*z, with z*z added combinationally
    assign sq_start = (state_reg == S_SQZ);
    assign sq_op    = sqy_reg + SQ_W'($unsigned(SQ_W'(z_reg) * SQ_W'(z_reg)));

    // cordic operands: pitch uses (sqrt, -x), roll folds negative z by 180 degrees
    assign cd_start = (state_reg == S_SQRT && sq_done) || (state_reg == S_ACC && !roll_reg);
    always_comb
    begin
        if (state_reg == S_SQRT)
        begin
            cd_xa   = OPND_W'($signed({1'b0, sq_root}));
            cd_ya   = -OPND_W'(x_reg);
            cd_base = '0;
        end
        else if (!z_reg[ACC_W-1])
        begin
            cd_xa   = OPND_W'(z_reg);
            cd_ya   = OPND_W'(y_reg);
            cd_base = '0;
        end
        else
        begin
            cd_xa   = -OPND_W'(z_reg);
            cd_ya   = -OPND_W'(y_reg);
            cd_base = y_reg[ACC_W-1] ? -DEG180_FINE : DEG180_FINE;
        end
    end

    acctilt_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sq_start),
        .operand (sq_op),
        .done    (sq_done),
        .root    (sq_root)
    );

    acctilt_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cd_start),
        .xa    (cd_xa),
        .ya    (cd_ya),
        .base  (cd_base),
        .done  (cd_done),
        .angle (cd_angle)
    );

    // angle limits and current filter state for the active channel
    always_comb
    begin
        if (roll_reg)
        begin
            lo_lim = ROLL_W'(-16384);
            hi_lim = ROLL_W'(16383);
            s_cur  = roll_st_reg;
        end
        else
        begin
            lo_lim = ROLL_W'(-8192);
            hi_lim = ROLL_W'(8191);
            s_cur  = ROLL_W'(pitch_reg);
        end
    end

    // round half up to output units, then saturate
    always_comb
    begin
        fine_rnd = (cd_angle + (FINE_W'(1) <<< (SHR - 1))) >>> SHR;
        if (fine_rnd < FINE_W'(lo_lim))
            units_next = lo_lim;
        else if (fine_rnd > FINE_W'(hi_lim))
            units_next = hi_lim;
        else
            units_next = ROLL_W'(fine_rnd);
    end

    assign gain_sat = (gain_reg > GAIN_W'(256)) ? (GAIN_W+1)'(256)
                                                : (GAIN_W+1)'(gain_reg);
    assign diff     = 17'(units_reg) - 17'(s_cur);
    assign acc_sum  = 20'(s_cur) + 20'(prod_reg >>> 8);

    // servo map on the current filtered pitch
    always_comb
    begin
        servo_sum = 16'(pitch_reg) + 16'($signed({2'b00, offset_reg}));
        if (servo_sum < 16'sd0)
            servo_val = '0;
        else if (servo_sum > 16'($signed({2'b00, smax_reg})))
            servo_val = smax_reg;
        else
            servo_val = SERVO_W'(servo_sum);
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        roll_next    = roll_reg;
        ecnt_next    = ecnt_reg;
        upd_next     = upd_reg;
        rst_req_next = rst_req_reg;
        pitch_next   = pitch_reg;
        roll_st_next = roll_st_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    roll_next = 1'b0;
                    if (invalid)
                    begin
                        upd_next = 1'b0;
                        if (ecnt_inc > elim_reg)
                        begin
                            rst_req_next = 1'b1;
                            ecnt_next    = '0;
                        end
                        else
                        begin
                            rst_req_next = 1'b0;
                            ecnt_next    = ecnt_inc;
                        end
                        state_next = S_DONE;
                    end
                    else
                    begin
                        upd_next     = 1'b1;
                        rst_req_next = 1'b0;
                        ecnt_next    = '0;
                        state_next   = S_SQY;
                    end
                end
            end
            S_SQY:  state_next = S_SQZ;
            S_SQZ:  state_next = S_SQRT;
            S_SQRT:
            begin
                if (sq_done)
                    state_next = S_CORD;
            end
            S_CORD:
            begin
                if (cd_done)
                    state_next = S_UNIT;
            end
            S_UNIT: state_next = S_MUL;
            S_MUL:  state_next = S_ACC;
            S_ACC:
            begin
                if (roll_reg)
                begin
                    if (acc_sum < 20'(lo_lim))
                        roll_st_next = lo_lim;
                    else if (acc_sum > 20'(hi_lim))
                        roll_st_next = hi_lim;
                    else
                        roll_st_next = ROLL_W'(acc_sum);
                    state_next = S_DONE;
                end
                else
                begin
                    if (acc_sum < 20'(lo_lim))
                        pitch_next = PITCH_W'(lo_lim);
                    else if (acc_sum > 20'(hi_lim))
                        pitch_next = PITCH_W'(hi_lim);
                    else
                        pitch_next = PITCH_W'(acc_sum);
                    roll_next  = 1'b1;
                    state_next = S_CORD;
                end
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            roll_reg    <= 1'b0;
            ecnt_reg    <= '0;
            upd_reg     <= 1'b0;
            rst_req_reg <= 1'b0;
            pitch_reg   <= '0;
            roll_st_reg <= '0;
            gain_reg    <= GAIN_W'(102);
            elim_reg    <= ELIM_W'(5);
            offset_reg  <= SERVO_W'(5760);
            smax_reg    <= SERVO_W'(11520);
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            roll_reg    <= roll_next;
            ecnt_reg    <= ecnt_next;
            upd_reg     <= upd_next;
            rst_req_reg <= rst_req_next;
            pitch_reg   <= pitch_next;
            roll_st_reg <= roll_st_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_FILTER_GAIN:  gain_reg   <= cfg_data[GAIN_W-1:0];
                    REG_ERROR_LIMIT:  elim_reg   <= cfg_data[ELIM_W-1:0];
                    REG_SERVO_OFFSET: offset_reg <= cfg_data[SERVO_W-1:0];
                    REG_SERVO_MAX:    smax_reg   <= cfg_data[SERVO_W-1:0];
                    default:          ;
                endcase
            end
            // output register: load on finish, clear when taken
            if (state_reg == S_DONE && out_free)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= accel_x;
            y_reg <= accel_y;
            z_reg <= accel_z;
        end
        if (state_reg == S_SQY)
            sqy_reg <= SQ_W'($unsigned(SQ_W'(y_reg) * SQ_W'(y_reg)));
        if (state_reg == S_CORD && cd_done)
            units_reg <= units_next;
        if (state_reg == S_MUL)
            prod_reg <= 27'(diff) * 27'(gain_sat);
        if (state_reg == S_DONE && out_free)
        begin
            o_upd_reg   <= upd_reg;
            o_rst_reg   <= rst_req_reg;
            o_pitch_reg <= pitch_reg;
            o_roll_reg  <= roll_st_reg;
            o_servo_reg <= servo_val;
        end
    end

    assign out_valid    = ov_reg;
    assign updated      = o_upd_reg;
    assign sensor_reset = o_rst_reg;
    assign pitch_out    = o_pitch_reg;
    assign roll_out     = o_roll_reg;
    assign servo_angle  = o_servo_reg;

    // a sensor reset request only comes with a held sample
    a_rst_not_upd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sensor_reset |-> !updated)
        else $error("sensor reset with updated angles");

    // a new result is only loaded from the finish state
    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside finish state");

    // cordic never restarted while an input could be accepted
    a_cordic_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cd_start |-> !in_ready)
        else $error("cordic started while idle");
endmodule

/* sim/tb.sv */
// self-checking testbench for the accelerometer tilt filter and servo map
`timescale 1ns / 1ps

module tb;
    import acctilt_pkg::*;

    localparam int  STEPS      = CORDIC_STEPS_DEF;
    localparam int  FRAC       = ANGLE_FRAC_BITS_DEF;
    localparam int  CYCLE_CAP  = 1000000;
    localparam int  SETTLE     = 80;      // a little more than the valid-sample latency
    localparam int  PHASE_LEN  = 125;

    typedef struct {
        logic                      upd;
        logic                      rst;
        logic signed [PITCH_W-1:0] pitch;
        logic signed [ROLL_W-1:0]  roll;
        logic [SERVO_W-1:0]        servo;
    } tilt_res_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_AW-1:0]         cfg_addr;
    logic [CFG_W-1:0]          cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [ACC_W-1:0]   accel_x;
    logic signed [ACC_W-1:0]   accel_y;
    logic signed [ACC_W-1:0]   accel_z;
    logic                      out_valid;
    logic                      out_ready;
    logic                      updated;
    logic                      sensor_reset;
    logic signed [PITCH_W-1:0] pitch_out;
    logic signed [ROLL_W-1:0]  roll_out;
    logic [SERVO_W-1:0]        servo_angle;

    // tilt predictor and store of expected outputs
    class tilt_scoreboard;
        longint    gain, err_limit, offset, smax;
        longint    pitch_s, roll_s, err_cnt;
        tilt_res_t pending[$];
        int        fails;

        function void clear_state();
            gain = 102; err_limit = 5; offset = 5760; smax = 11520;
            pitch_s = 0; roll_s = 0; err_cnt = 0;
            fails = 0;
        endfunction

        function void set_reg(logic [CFG_AW-1:0] addr, logic [CFG_W-1:0] val);
            case (addr)
                REG_FILTER_GAIN:  gain      = val[GAIN_W-1:0];
                REG_ERROR_LIMIT:  err_limit = val[ELIM_W-1:0];
                REG_SERVO_OFFSET: offset    = val;
                REG_SERVO_MAX:    smax      = val;
                default: ;
            endcase
        endfunction

        function longint int_sqrt(longint s);
            longint r, b;
            r = 0;
            b = longint'(1) << 32;
            while (b > s) b = b >> 2;
            while (b != 0) begin
                if (s >= r + b) begin
                    s = s - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function longint atan_step(int i);
            case (i)
                0: return 2949120;  1: return 1740967;  2: return 919879;
                3: return 466945;   4: return 234379;   5: return 117304;
                6: return 58666;    7: return 29335;    8: return 14668;
                9: return 7334;     10: return 3667;    11: return 1833;
                12: return 917;     13: return 458;     14: return 229;
                15: return 115;     16: return 57;      17: return 29;
                18: return 14;      19: return 7;       20: return 4;
                21: return 2;       22: return 1;
                default: return 0;
            endcase
        endfunction

        // vectoring rotation, xa >= 0, angle in 1/65536 degree
        function longint vec_angle(longint xa, longint ya);
            longint vx, vy, acc, dx, dy;
            vx = xa * 16384;
            vy = ya * 16384;
            acc = 0;
            if (xa == 0 && ya == 0) return 0;
            for (int i = 0; i < STEPS; i++) begin
                dx = vy >>> i;
                dy = vx >>> i;
                if (vy >= 0) begin
                    vx += dx; vy -= dy; acc += atan_step(i);
                end else begin
                    vx -= dx; vy += dy; acc -= atan_step(i);
                end
            end
            return acc;
        endfunction

        function longint clampv(longint v, longint lo, longint hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function longint fine_to_units(longint fine, longint lo, longint hi);
            return clampv((fine + (longint'(1) << (15 - FRAC))) >>> (16 - FRAC), lo, hi);
        endfunction

        function longint smooth(longint s, longint a, longint lo, longint hi);
            longint g;
            g = (gain > 256) ? 256 : gain;
            return clampv(s + ((g * (a - s)) >>> 8), lo, hi);
        endfunction

        function void note_sample(logic signed [ACC_W-1:0] ax, logic signed [ACC_W-1:0] ay,
                                  logic signed [ACC_W-1:0] az);
            longint x, y, z, mag, pf, rf, sv;
            tilt_res_t r;
            x = ax; y = ay; z = az;
            r.upd = 0;
            r.rst = 0;
            if ((x == 0 && y == 0 && z == 0) || (x == -1 && y == -1 && z == -1)) begin
                if (err_cnt < 255) err_cnt++;
                if (err_cnt > err_limit) begin
                    r.rst = 1;
                    err_cnt = 0;
                end
            end else begin
                err_cnt = 0;
                r.upd = 1;
                mag = int_sqrt(y * y + z * z);
                pf = vec_angle(mag, -x);
                if (z >= 0)
                    rf = vec_angle(z, y);
                else
                    rf = ((y >= 0) ? 180 * 65536 : -180 * 65536) + vec_angle(-z, -y);
                pitch_s = smooth(pitch_s, fine_to_units(pf, -8192, 8191), -8192, 8191);
                roll_s  = smooth(roll_s, fine_to_units(rf, -16384, 16383), -16384, 16383);
            end
            sv = clampv(pitch_s + offset, 0, 1 << 30);
            if (sv > smax) sv = smax;
            r.pitch = pitch_s[PITCH_W-1:0];
            r.roll  = roll_s[ROLL_W-1:0];
            r.servo = sv[SERVO_W-1:0];
            pending.push_back(r);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            fails++;
        endtask

        task check_result(tilt_res_t got);
            tilt_res_t w;
            if (pending.size() == 0) begin
                report("output transaction with nothing expected");
                return;
            end
            w = pending.pop_front();
            if (got.upd !== w.upd)
                report($sformatf("updated got %0b want %0b", got.upd, w.upd));
            if (got.rst !== w.rst)
                report($sformatf("sensor_reset got %0b want %0b", got.rst, w.rst));
            if (got.pitch !== w.pitch)
                report($sformatf("pitch_out got %0d want %0d", got.pitch, w.pitch));
            if (got.roll !== w.roll)
                report($sformatf("roll_out got %0d want %0d", got.roll, w.roll));
            if (got.servo !== w.servo)
                report($sformatf("servo_angle got %0d want %0d", got.servo, w.servo));
        endtask
    endclass

    tilt_scoreboard tilt_sb;
    int             sent;
    int             cycles;
    int             hold_left;
    int             last_hold_mark;
    int             stall_mode;

    accel_tilt_filter_servo_map dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .updated      (updated),
        .sensor_reset (sensor_reset),
        .pitch_out    (pitch_out),
        .roll_out     (roll_out),
        .servo_angle  (servo_angle)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog, counts every cycle from time zero
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stall patterns, plus two long hold-offs
    // while the sender keeps offering, so the block backs up and drops in_ready
    initial
    begin
        out_ready = 1'b0;
        hold_left = 0;
        last_hold_mark = 0;
        stall_mode = 0;
        forever
        begin
            @(posedge clk);
            if (cycles % 250 == 0)
                stall_mode = $urandom_range(0, 3);
            if (hold_left == 0 && (sent == 300 || sent == 900) && last_hold_mark != sent)
            begin
                last_hold_mark = sent;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // output monitor, every accepted result transaction is checked in order
    always @(posedge clk)
    begin
        tilt_res_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.upd   = updated;
            got.rst   = sensor_reset;
            got.pitch = pitch_out;
            got.roll  = roll_out;
            got.servo = servo_angle;
            tilt_sb.check_result(got);
        end
    end

    // register write, only called while the block is idle
    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        tilt_sb.set_reg(addr, val);
        @(posedge clk);
    endtask

    // offer one sample and hold it until the transaction happens
    task automatic push_sample(input logic [ACC_W-1:0] x, input logic [ACC_W-1:0] y,
                               input logic [ACC_W-1:0] z);
        in_valid <= 1'b1;
        accel_x  <= x;
        accel_y  <= y;
        accel_z  <= z;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tilt_sb.note_sample(x, y, z);
        sent++;
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // stop sending until every expected result is back, then let the pipe settle
    task automatic drain();
        in_valid <= 1'b0;
        while (tilt_sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_all(input logic [CFG_W-1:0] g, input logic [CFG_W-1:0] l,
                             input logic [CFG_W-1:0] o, input logic [CFG_W-1:0] m);
        write_reg(REG_FILTER_GAIN, g);
        write_reg(REG_ERROR_LIMIT, l);
        write_reg(REG_SERVO_OFFSET, o);
        write_reg(REG_SERVO_MAX, m);
    endtask

    // random sample: mostly real tilt vectors, some invalid patterns and near misses
    task automatic pick_sample(output logic [ACC_W-1:0] x, output logic [ACC_W-1:0] y,
                               output logic [ACC_W-1:0] z);
        int k;
        k = $urandom_range(0, 19);
        x = ACC_W'($urandom); y = ACC_W'($urandom); z = ACC_W'($urandom);
        if (k < 3)
        begin
            x = ACC_W'($urandom_range(0, 64) - 32);
            y = ACC_W'($urandom_range(0, 64) - 32);
            z = ACC_W'($urandom_range(0, 64) - 32);
        end
        else if (k < 5)
        begin
            x = 16'h0000; y = 16'h0000; z = 16'h0000;
        end
        else if (k < 7)
        begin
            x = 16'hffff; y = 16'hffff; z = 16'hffff;
        end
        else if (k == 7)
        begin
            // one axis off the invalid pattern
            x = 16'h0000; y = 16'h0000; z = 16'h0000;
            case ($urandom_range(0, 2))
                0: x = 16'h0001 << $urandom_range(0, 15);
                1: y = 16'h0001 << $urandom_range(0, 15);
                default: z = 16'h0001 << $urandom_range(0, 15);
            endcase
        end
        else if (k == 8)
        begin
            x = 16'hffff; y = 16'hffff; z = 16'hffff ^ (16'h0001 << $urandom_range(0, 15));
        end
        else if (k < 11)
        begin
            z[15] = 1'b1;   // upside down, roll wraps through 180
        end
    endtask

    initial
    begin
        logic [ACC_W-1:0] rx, ry, rz;
        int burst;

        tilt_sb   = new();
        tilt_sb.clear_state();
        sent      = 0;
        cycles    = 0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        accel_x   = '0;
        accel_y   = '0;
        accel_z   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // directed samples at reset defaults
        push_sample(16'h0000, 16'h0000, 16'h4000);
        push_sample(16'h7fff, 16'h0000, 16'h0000);
        push_sample(16'h8000, 16'h0000, 16'h0000);
        push_sample(16'h0064, 16'h0000, 16'h0000);    // roll operands both zero
        push_sample(16'h8000, 16'h8000, 16'h8000);
        push_sample(16'h7fff, 16'h7fff, 16'h7fff);
        push_sample(16'h0000, 16'h0064, 16'hc000);    // negative z, y positive
        push_sample(16'h0000, 16'hff9c, 16'hc000);    // negative z, y negative
        push_sample(16'h0000, 16'h0000, 16'h8000);    // negative z, y zero
        idle_gap(3);
        // seven invalid samples; the sixth exceeds the default limit of five
        push_sample(16'h0000, 16'h0000, 16'h0000);
        push_sample(16'hffff, 16'hffff, 16'hffff);
        push_sample(16'h0000, 16'h0000, 16'h0000);
        push_sample(16'hffff, 16'hffff, 16'hffff);
        push_sample(16'h0000, 16'h0000, 16'h0000);
        push_sample(16'hffff, 16'hffff, 16'hffff);
        push_sample(16'h0000, 16'h0000, 16'h0000);
        push_sample(16'h1234, 16'hedcb, 16'h0100);
        drain();

        // extreme settings: zero everywhere, limit zero resets on every invalid sample
        write_all(14'd0, 14'd0, 14'd0, 14'd0);
        push_sample(16'h0000, 16'h0000, 16'h0000);
        push_sample(16'h4000, 16'h0000, 16'h1000);
        push_sample(16'hffff, 16'hffff, 16'hffff);
        drain();
        // full gain, saturated gain, top limit, offset and clamp both at 11520
        write_all(14'd256, 14'd255, 14'd11520, 14'd11520);
        push_sample(16'h8000, 16'h0000, 16'h0010);
        drain();
        write_reg(REG_FILTER_GAIN, 14'd511);
        push_sample(16'h7fff, 16'h0000, 16'h0010);
        drain();

        // random phases, each with its own register setting
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0:  write_all(14'd102, 14'd5, 14'd5760, 14'd11520);
                1:  write_all(14'd256, 14'd255, 14'd16383, 14'd16383);
                2:  write_all(14'd0, 14'd0, 14'd0, 14'd11520);
                3:  write_all(14'd511, 14'd1, 14'd11520, 14'd0);
                default: write_all(CFG_W'($urandom_range(0, 511)),
                                   CFG_W'($urandom_range(0, 255)),
                                   CFG_W'($urandom_range(0, 16383)),
                                   CFG_W'($urandom_range(0, 16383)));
            endcase
            for (int n = 0; n < PHASE_LEN; )
            begin
                burst = $urandom_range(1, 24);
                for (int b = 0; b < burst; b++)
                begin
                    pick_sample(rx, ry, rz);
                    push_sample(rx, ry, rz);
                    n++;
                end
                if ($urandom_range(0, 9) == 0)
                    drain();
                else if ($urandom_range(0, 2) != 0)
                    idle_gap($urandom_range(1, 70));
            end
            drain();
        end

        // wait for the last result, then a settling window
        in_valid <= 1'b0;
        while (tilt_sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (tilt_sb.fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
design/acctilt_pkg.sv
design/acctilt_sqrt.sv
design/acctilt_cordic.sv
design/accel_tilt_filter_servo_map.sv
sim/tb.sv
